[hw/rtl/assert_macros.svh]
// Assertion helpers, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

[hw/rtl/rlv_pkg.sv]
package rlv_pkg;

   localparam int FRAC_BITS   = 30;
   localparam int MANT_BITS   = 32;
   localparam int LOG_ITERS   = 30;
   localparam int RET_BITS    = 32;
   localparam int WIN_W       = 9;
   localparam int FACTOR_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int VOL_W       = 32;
   localparam int SAMPLES_W   = 9;
   localparam int SUM_SQ_W    = 64;
   localparam int SQ_SHIFT    = 8;
   localparam int VAR_SHIFT   = 12;
   localparam int SCALED_W    = SUM_SQ_W - VAR_SHIFT;

   // ln(2) in Q0.28.
   localparam logic [27:0] LN2_Q28 = 28'd186065280;
   localparam logic [RET_BITS-1:0] RET_MAX = 32'h7FFF_FFFF;

   localparam logic [WIN_W-1:0]    WINDOW_RESET = 9'd20;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd252;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANNUAL_FACTOR = 1'd1;

   typedef struct packed {
      logic [RET_BITS-1:0] log_ret;
      logic                restart;
   } rlv_item_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_NORM,
      F_LOG,
      F_DIFF,
      F_MUL,
      F_RET,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SQ_NEW,
      B_SQ_OLD,
      B_DIV_MEAN,
      B_DIV_VAR,
      B_MEAN_SQ,
      B_VAR_SUB,
      B_SCALE_LO,
      B_SCALE_HI,
      B_SQRT,
      B_DONE
   } back_state_type;

endpackage

[hw/rtl/rlv_req_if.sv]
interface rlv_req_if #(
   parameter int PRICE_BITS = 32
) ();
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] price;
   logic                  restart;

   modport source (output valid, output price, output restart, input ready);
   modport sink (input valid, input price, input restart, output ready);
endinterface

[hw/rtl/rlv_rsp_if.sv]
interface rlv_rsp_if ();
   logic        valid;
   logic        ready;
   logic [31:0] volatility;
   logic [8:0]  samples_used;

   modport source (output valid, output volatility, output samples_used, input ready);
   modport sink (input valid, input volatility, input samples_used, output ready);
endinterface

[hw/rtl/rolling_log_return_volatility.sv]
// Rolling historical volatility: one closing price in, one result out per bar. The front end
// takes a bar, finds the leading one of the price one bit per cycle, forms log2 with 30
// squaring steps and turns the difference into a log return in the DIFF, MUL and RET states.
// A two-entry queue passes the return to the back end, which updates the window sums through
// one shared 32x32 multiplier, runs two serial divisions (mean and mean square) and a serial
// square root, skipped when the variance is not positive. The back end takes a new return only
// when idle, which sets the sustained rate. The first bar of a series and a restart bar go
// straight from IDLE to DONE with a zero result. Writing window_length clears the series;
// write registers only while idle.
`include "assert_macros.svh"

module rolling_log_return_volatility #(
   parameter int MAX_WINDOW = 256,
   parameter int PRICE_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   rlv_req_if.sink                         req,
   rlv_rsp_if.source                       rsp,
   input  logic                            csr_write_enable,
   input  logic [rlv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rlv_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rlv_pkg::*;

   rlv_item_type q_in_item, q_out_item;
   logic         q_in_valid, q_in_ready;
   logic         q_out_valid, q_out_ready;

   rlv_front #(
      .PRICE_BITS (PRICE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_item  (q_in_item),
      .push_valid (q_in_valid),
      .push_ready (q_in_ready)
   );

   rlv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (q_in_item),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .out_item  (q_out_item),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready)
   );

   rlv_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_item         (q_out_item),
      .pop_valid        (q_out_valid),
      .pop_ready        (q_out_ready),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp              (rsp)
   );

   `ASSERT_NEXT(a_push_held, clock, reset, q_in_valid && !q_in_ready, q_in_valid)
   `ASSERT_NEXT(a_front_one_item, clock, reset, req.valid && req.ready, !req.ready)
   `ASSERT_NEXT(a_back_busy_after_pop, clock, reset, q_out_valid && q_out_ready, !q_out_ready)
   `ASSERT_IMPLIES(a_push_while_busy, clock, reset, q_in_valid, !req.ready)

endmodule

[hw/rtl/rlv_front.sv]
module rlv_front #(
   parameter int PRICE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   rlv_req_if.sink              req,
   output rlv_pkg::rlv_item_type push_item,
   output logic                 push_valid,
   input  logic                 push_ready
);
   import rlv_pkg::*;

   localparam int XW  = (PRICE_BITS > MANT_BITS) ? PRICE_BITS : MANT_BITS;
   localparam int EW  = $clog2(PRICE_BITS);
   localparam int LW  = EW + FRAC_BITS;
   localparam int PHW = LW - 32 + 28;
   localparam int TW  = LW + 32;

   front_state_type       state_ff, state_in;
   logic [XW-1:0]         x_ff, x_in;
   logic [EW-1:0]         exp_ff, exp_in;
   logic [MANT_BITS-1:0]  mant_ff, mant_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic [4:0]            iter_ff, iter_in;
   logic [LW-1:0]         cur_log_ff, cur_log_in;
   logic [LW-1:0]         prev_log_ff, prev_log_in;
   logic                  cur_zero_ff, cur_zero_in;
   logic                  prev_zero_ff, prev_zero_in;
   logic                  restart_ff, restart_in;
   logic                  neg_ff, neg_in;
   logic [LW-1:0]         mag_ff, mag_in;
   logic [59:0]           plo_ff, plo_in;
   logic [PHW-1:0]        phi_ff, phi_in;
   logic [RET_BITS-1:0]   ret_ff, ret_in;

   logic [63:0]           mant_sq;
   logic [32:0]           mant_next;
   logic [TW-1:0]         total;
   logic [RET_BITS-1:0]   ret_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         prev_zero_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         prev_zero_ff <= prev_zero_in;
      end
      x_ff        <= x_in;
      exp_ff      <= exp_in;
      mant_ff     <= mant_in;
      frac_ff     <= frac_in;
      iter_ff     <= iter_in;
      cur_log_ff  <= cur_log_in;
      prev_log_ff <= prev_log_in;
      cur_zero_ff <= cur_zero_in;
      restart_ff  <= restart_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      ret_ff      <= ret_in;
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      exp_in       = exp_ff;
      mant_in      = mant_ff;
      frac_in      = frac_ff;
      iter_in      = iter_ff;
      cur_log_in   = cur_log_ff;
      prev_log_in  = prev_log_ff;
      cur_zero_in  = cur_zero_ff;
      prev_zero_in = prev_zero_ff;
      restart_in   = restart_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      ret_in       = ret_ff;

      mant_sq   = 64'(mant_ff) * 64'(mant_ff);
      mant_next = mant_sq[63:31];
      total     = TW'(plo_ff) + (TW'(phi_ff) << 32) + (TW'(1) << 31);
      ret_mag   = ((total >> 32) > TW'(RET_MAX)) ? RET_MAX : total[63:32];

      unique case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               x_in        = XW'(req.price) << (XW - PRICE_BITS);
               exp_in      = EW'(PRICE_BITS - 1);
               restart_in  = req.restart;
               cur_zero_in = (req.price == '0);
               frac_in     = '0;
               iter_in     = '0;
               state_in    = (req.price == '0) ? F_DIFF : F_NORM;
            end
         end
         F_NORM: begin
            // Shift until the leading one sits at the top of the word.
            if (x_ff[XW-1]) begin
               mant_in  = x_ff[XW-1 -: MANT_BITS];
               state_in = F_LOG;
            end else begin
               x_in   = x_ff << 1;
               exp_in = exp_ff - 1'b1;
            end
         end
         F_LOG: begin
            // One fraction bit of log2 per squaring of the mantissa.
            if (mant_next[32]) begin
               mant_in = mant_next[32:1];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               mant_in = mant_next[31:0];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == 5'(LOG_ITERS - 1)) begin
               cur_log_in = {exp_ff, frac_in};
               state_in   = F_DIFF;
            end
         end
         F_DIFF: begin
            if (cur_zero_ff || prev_zero_ff) begin
               neg_in = 1'b0;
               mag_in = '0;
            end else if (cur_log_ff < prev_log_ff) begin
               neg_in = 1'b1;
               mag_in = prev_log_ff - cur_log_ff;
            end else begin
               neg_in = 1'b0;
               mag_in = cur_log_ff - prev_log_ff;
            end
            state_in = F_MUL;
         end
         F_MUL: begin
            plo_in   = 60'(mag_ff[31:0]) * 60'(LN2_Q28);
            phi_in   = PHW'(mag_ff[LW-1:32]) * PHW'(LN2_Q28);
            state_in = F_RET;
         end
         F_RET: begin
            ret_in       = neg_ff ? (~ret_mag + 1'b1) : ret_mag;
            prev_log_in  = cur_log_ff;
            prev_zero_in = cur_zero_ff;
            state_in     = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign req.ready         = (state_ff == F_IDLE);
   assign push_valid        = (state_ff == F_PUSH);
   assign push_item.log_ret = ret_ff;
   assign push_item.restart = restart_ff;

endmodule

[hw/rtl/rlv_queue.sv]
module rlv_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  rlv_pkg::rlv_item_type in_item,
   input  logic                  in_valid,
   output logic                  in_ready,
   output rlv_pkg::rlv_item_type out_item,
   output logic                  out_valid,
   input  logic                  out_ready
);
   import rlv_pkg::*;

   rlv_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[hw/rtl/rlv_back.sv]
module rlv_back #(
   parameter int MAX_WINDOW = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rlv_pkg::rlv_item_type               pop_item,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  logic                                csr_write_enable,
   input  logic [rlv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rlv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   rlv_rsp_if.source                           rsp
);
   import rlv_pkg::*;

   localparam int PW = $clog2(MAX_WINDOW);
   localparam int NW = $clog2(MAX_WINDOW + 1);
   localparam int BW = $clog2(MAX_WINDOW + 2);
   localparam int SW = 33 + PW;

   back_state_type        state_ff, state_in;
   logic [WIN_W-1:0]      window_length_ff, window_length_in;
   logic [FACTOR_W-1:0]   annual_factor_ff, annual_factor_in;
   logic [PW-1:0]         ptr_ff, ptr_in;
   logic [SW-1:0]         rsum_ff, rsum_in;
   logic [SUM_SQ_W-1:0]   ssum_ff, ssum_in;
   logic [BW-1:0]         bars_ff, bars_in;
   logic [RET_BITS-1:0]   ret_ff, ret_in;
   logic                  evict_ff, evict_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [63:0]           dq_ff, dq_in;
   logic [NW-1:0]         rem_ff, rem_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [31:0]           mean_ff, mean_in;
   logic [63:0]           var_ff, var_in;
   logic [63:0]           msq_ff, msq_in;
   logic [SCALED_W-1:0]   v_ff, v_in;
   logic [63:0]           plo_ff, plo_in;
   logic [63:0]           sx_ff, sx_in;
   logic [63:0]           res_ff, res_in;
   logic [63:0]           bit_ff, bit_in;
   logic [VOL_W-1:0]      vol_ff, vol_in;
   logic [SAMPLES_W-1:0]  samples_ff, samples_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VOL_W-1:0]      rsp_vol_ff, rsp_vol_in;
   logic [SAMPLES_W-1:0]  rsp_samples_ff, rsp_samples_in;

   logic [RET_BITS-1:0]   ring [MAX_WINDOW];
   logic [RET_BITS-1:0]   rd_ff;

   logic                  take;
   logic                  ring_we;
   logic [NW-1:0]         w;
   logic [31:0]           raddr_sum;
   logic [PW-1:0]         raddr;
   logic [BW-1:0]         bars_next;
   logic [31:0]           mul_a, mul_b;
   logic [63:0]           prod;
   logic [NW:0]           rem_ext;
   logic                  qbit;
   logic [NW-1:0]         rem_next;
   logic [63:0]           dq_next;
   logic [SW-1:0]         rsum_mag;
   logic [FACTOR_W-1:0]   factor;
   logic [63:0]           sq_try;

   function automatic logic [31:0] abs32(input logic [31:0] v);
      abs32 = v[31] ? (~v + 1'b1) : v;
   endfunction

   always_comb begin
      if (window_length_ff == '0) begin
         w = NW'(1);
      end else if (32'(window_length_ff) > 32'(MAX_WINDOW)) begin
         w = NW'(MAX_WINDOW);
      end else begin
         w = NW'(window_length_ff);
      end
      raddr_sum = 32'(ptr_ff) + 32'(MAX_WINDOW) - 32'(w);
      raddr     = (raddr_sum >= 32'(MAX_WINDOW)) ? PW'(raddr_sum - 32'(MAX_WINDOW))
                                                 : PW'(raddr_sum);
      bars_next = (32'(bars_ff) < 32'(MAX_WINDOW + 1)) ? bars_ff + 1'b1 : bars_ff;
      factor    = (annual_factor_ff == '0) ? FACTOR_W'(1) : annual_factor_ff;
      rsum_mag  = rsum_ff[SW-1] ? (~rsum_ff + 1'b1) : rsum_ff;

      // Restoring division, one quotient bit per cycle.
      rem_ext  = {rem_ff, dq_ff[63]};
      qbit     = (rem_ext >= {1'b0, n_ff});
      rem_next = qbit ? NW'(rem_ext - {1'b0, n_ff}) : rem_ext[NW-1:0];
      dq_next  = {dq_ff[62:0], qbit};

      sq_try = res_ff + bit_ff;
   end

   // The one multiplier of the back end, shared by every product step.
   always_comb begin
      unique case (state_ff)
         B_SQ_NEW: begin
            mul_a = abs32(ret_ff);
            mul_b = abs32(ret_ff);
         end
         B_SQ_OLD: begin
            mul_a = abs32(rd_ff);
            mul_b = abs32(rd_ff);
         end
         B_MEAN_SQ: begin
            mul_a = mean_ff;
            mul_b = mean_ff;
         end
         B_SCALE_LO: begin
            mul_a = v_ff[31:0];
            mul_b = 32'(factor);
         end
         B_SCALE_HI: begin
            mul_a = 32'(v_ff[SCALED_W-1:32]);
            mul_b = 32'(factor);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = 64'(mul_a) * 64'(mul_b);
   end

   assign take      = (state_ff == B_IDLE) && pop_valid;
   assign pop_ready = (state_ff == B_IDLE);
   assign ring_we   = take && !pop_item.restart && (bars_ff != '0);

   always_comb begin
      state_in         = state_ff;
      window_length_in = window_length_ff;
      annual_factor_in = annual_factor_ff;
      ptr_in           = ptr_ff;
      rsum_in          = rsum_ff;
      ssum_in          = ssum_ff;
      bars_in          = bars_ff;
      ret_in           = ret_ff;
      evict_in         = evict_ff;
      n_in             = n_ff;
      dq_in            = dq_ff;
      rem_in           = rem_ff;
      cnt_in           = cnt_ff;
      mean_in          = mean_ff;
      var_in           = var_ff;
      msq_in           = msq_ff;
      v_in             = v_ff;
      plo_in           = plo_ff;
      sx_in            = sx_ff;
      res_in           = res_ff;
      bit_in           = bit_ff;
      vol_in           = vol_ff;
      samples_in       = samples_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      rsp_vol_in       = rsp_vol_ff;
      rsp_samples_in   = rsp_samples_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               if (pop_item.restart || (bars_ff == '0)) begin
                  rsum_in    = '0;
                  ssum_in    = '0;
                  bars_in    = BW'(1);
                  vol_in     = '0;
                  samples_in = '0;
                  state_in   = B_DONE;
               end else begin
                  ret_in   = pop_item.log_ret;
                  evict_in = (32'(bars_ff) - 32'd1 >= 32'(w));
                  ptr_in   = (32'(ptr_ff) == 32'(MAX_WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
                  bars_in  = bars_next;
                  n_in     = (32'(bars_next) - 32'd1 > 32'(w)) ? w : NW'(bars_next - 1'b1);
                  state_in = B_SQ_NEW;
               end
            end
         end
         B_SQ_NEW: begin
            rsum_in = rsum_ff + {{(SW - 32){ret_ff[31]}}, ret_ff}
                      - (evict_ff ? {{(SW - 32){rd_ff[31]}}, rd_ff} : '0);
            ssum_in = ssum_ff + (prod >> SQ_SHIFT);
            state_in = B_SQ_OLD;
         end
         B_SQ_OLD: begin
            if (evict_ff) begin
               ssum_in = ssum_ff - (prod >> SQ_SHIFT);
            end
            dq_in    = 64'(rsum_mag);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = B_DIV_MEAN;
         end
         B_DIV_MEAN: begin
            dq_in  = dq_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) begin
               // Only the magnitude matters: the mean is used only in its square.
               mean_in  = dq_next[31:0];
               dq_in    = ssum_ff;
               rem_in   = '0;
               state_in = B_DIV_VAR;
            end
         end
         B_DIV_VAR: begin
            dq_in  = dq_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) begin
               var_in   = dq_next;
               state_in = B_MEAN_SQ;
            end
         end
         B_MEAN_SQ: begin
            msq_in   = prod >> SQ_SHIFT;
            state_in = B_VAR_SUB;
         end
         B_VAR_SUB: begin
            samples_in = SAMPLES_W'(n_ff);
            if (var_ff <= msq_ff) begin
               vol_in   = '0;
               state_in = B_DONE;
            end else begin
               v_in     = SCALED_W'((var_ff - msq_ff) >> VAR_SHIFT);
               state_in = B_SCALE_LO;
            end
         end
         B_SCALE_LO: begin
            plo_in   = prod;
            state_in = B_SCALE_HI;
         end
         B_SCALE_HI: begin
            // The scaled variance wraps at 64 bits.
            sx_in    = plo_ff + {prod[31:0], 32'b0};
            res_in   = '0;
            bit_in   = 64'(1) << 62;
            cnt_in   = '0;
            state_in = B_SQRT;
         end
         B_SQRT: begin
            if (sx_ff >= sq_try) begin
               sx_in  = sx_ff - sq_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd31) begin
               vol_in   = (res_in > 64'hFFFF_FFFF) ? '1 : res_in[31:0];
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_vol_in     = vol_ff;
               rsp_samples_in = samples_ff;
               state_in       = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: begin
               window_length_in = csr_wdata[WIN_W-1:0];
               bars_in          = '0;
               rsum_in          = '0;
               ssum_in          = '0;
            end
            CSR_ANNUAL_FACTOR: begin
               annual_factor_in = csr_wdata[FACTOR_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= B_IDLE;
         window_length_ff <= WINDOW_RESET;
         annual_factor_ff <= FACTOR_RESET;
         ptr_ff           <= '0;
         rsum_ff          <= '0;
         ssum_ff          <= '0;
         bars_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         window_length_ff <= window_length_in;
         annual_factor_ff <= annual_factor_in;
         ptr_ff           <= ptr_in;
         rsum_ff          <= rsum_in;
         ssum_ff          <= ssum_in;
         bars_ff          <= bars_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      ret_ff         <= ret_in;
      evict_ff       <= evict_in;
      n_ff           <= n_in;
      dq_ff          <= dq_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      mean_ff        <= mean_in;
      var_ff         <= var_in;
      msq_ff         <= msq_in;
      v_ff           <= v_in;
      plo_ff         <= plo_in;
      sx_ff          <= sx_in;
      res_ff         <= res_in;
      bit_ff         <= bit_in;
      vol_ff         <= vol_in;
      samples_ff     <= samples_in;
      rsp_vol_ff     <= rsp_vol_in;
      rsp_samples_ff <= rsp_samples_in;
   end

   // Read before write: with a full-ring window the oldest entry shares the write address.
   always_ff @(posedge clock) begin
      if (take) begin
         rd_ff <= ring[raddr];
      end
      if (ring_we) begin
         ring[ptr_ff] <= pop_item.log_ret;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.volatility   = rsp_vol_ff;
   assign rsp.samples_used = rsp_samples_ff;

endmodule

[tb/rolling_log_return_volatility_tb.sv]
module rolling_log_return_volatility_tb;
   import rlv_pkg::*;

   localparam int WIN_MAX = 256;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [31:0] volatility;
      logic [8:0]  samples_used;
   } vol_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_WINDOW_LENGTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rlv_req_if #(.PRICE_BITS(32)) req ();
   rlv_rsp_if rsp ();

   rolling_log_return_volatility #(.MAX_WINDOW(WIN_MAX), .PRICE_BITS(32)) DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state.
   logic [31:0] ring_q26 [WIN_MAX];
   int unsigned ring_ptr;
   longint signed ret_sum;
   longint unsigned sq_sum;
   int unsigned bar_count;
   longint unsigned prev_price;
   int unsigned win_len;
   int unsigned ann_factor;

   vol_result_type expected_vol_q[$];
   int error_count = 0;
   int result_count = 0;
   int bar_total = 0;
   int idle_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned log2_fixed(longint unsigned x);
      int e;
      longint unsigned m, frac;
      e = 63;
      frac = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return (longint'(e) << 30) | frac;
   endfunction

   function automatic longint signed bar_log_return(longint unsigned cur, longint unsigned prv);
      longint unsigned a, b, mag;
      bit neg;
      if (cur == 0 || prv == 0) return 0;
      a = log2_fixed(cur);
      b = log2_fixed(prv);
      neg = a < b;
      mag = neg ? b - a : a - b;
      mag = (mag * 64'd186065280 + (64'd1 << 31)) >> 32;
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic vol_result_type predict_volatility(logic [31:0] price, logic restart);
      vol_result_type res;
      int unsigned w, n;
      longint signed r, old, mean;
      longint unsigned msq, var_q44, fac, vol;
      res.volatility = '0;
      res.samples_used = '0;
      if (restart || bar_count == 0) begin
         ret_sum = 0;
         sq_sum = 0;
         bar_count = 1;
         prev_price = price;
         return res;
      end
      w = (win_len == 0) ? 1 : (win_len > WIN_MAX ? WIN_MAX : win_len);
      r = bar_log_return(price, prev_price);
      if (bar_count - 1 >= w) begin
         old = longint'(signed'(ring_q26[(ring_ptr + WIN_MAX - w) % WIN_MAX]));
         ret_sum -= old;
         sq_sum -= longint'(unsigned'(old * old)) >> 8;
      end
      ring_q26[ring_ptr] = r[31:0];
      ring_ptr = (ring_ptr + 1) % WIN_MAX;
      ret_sum += r;
      sq_sum += longint'(unsigned'(r * r)) >> 8;
      if (bar_count < WIN_MAX + 1) bar_count++;
      prev_price = price;
      n = bar_count - 1;
      if (n > w) n = w;
      mean = ret_sum / longint'(n);
      msq = longint'(unsigned'(mean * mean)) >> 8;
      var_q44 = sq_sum / n;
      if (var_q44 <= msq) begin
         vol = 0;
      end else begin
         var_q44 -= msq;
         fac = (ann_factor == 0) ? 1 : ann_factor;
         vol = int_sqrt((var_q44 >> 12) * fac);
         if (vol > 64'hFFFF_FFFF) vol = 64'hFFFF_FFFF;
      end
      res.volatility = vol[31:0];
      res.samples_used = n[8:0];
      return res;
   endfunction

   // Result side: random stalls and comparison against the oldest prediction.
   initial begin
      int wait_cycles;
      rsp.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (wait_cycles != 0) begin
            rsp.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock iff rsp.valid);
         result_count++;
         if (expected_vol_q.size() == 0) begin
            $error("unexpected result: volatility %0h samples_used %0d",
                   rsp.volatility, rsp.samples_used);
            error_count++;
         end else begin
            vol_result_type e;
            e = expected_vol_q.pop_front();
            if (rsp.volatility !== e.volatility) begin
               $error("volatility expected %0h actual %0h", e.volatility, rsp.volatility);
               error_count++;
            end
            if (rsp.samples_used !== e.samples_used) begin
               $error("samples_used expected %0d actual %0d", e.samples_used,
                      rsp.samples_used);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (!reset && idle_cycles >= STALL_LIMIT) begin
         $display("rolling_log_return_volatility_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_bar(logic [31:0] price, logic restart);
      int wait_cycles;
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_cycles != 0) begin
         req.valid <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.price <= price;
      req.restart <= restart;
      expected_vol_q.push_back(predict_volatility(price, restart));
      bar_total++;
      @(posedge clock iff req.ready);
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (expected_vol_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_WINDOW_LENGTH) begin
         win_len = value & 16'h1FF;
         bar_count = 0;
         ret_sum = 0;
         sq_sum = 0;
      end else begin
         ann_factor = value;
      end
   endtask

   function automatic logic [31:0] next_price(logic [31:0] p);
      longint signed step;
      longint signed q;
      if (p == 0) return $urandom_range(1, 100000);
      step = longint'(p) * $urandom_range(0, 400) / 10000;
      q = ($urandom_range(0, 1) ? longint'(p) + step : longint'(p) - step);
      if (q < 1) q = 1;
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
      return q[31:0];
   endfunction

   task automatic test_extremes();
      send_bar(32'd1000, 1'b1);
      send_bar(32'hFFFF_FFFF, 1'b0);
      send_bar(32'd1, 1'b0);
      send_bar(32'hFFFF_FFFF, 1'b0);
      send_bar(32'd0, 1'b0);
      send_bar(32'd0, 1'b0);
      send_bar(32'd500, 1'b0);
      send_bar(32'd500, 1'b0);
      send_bar(32'h8000_0000, 1'b0);
      send_bar(32'h7FFF_FFFF, 1'b0);
      send_bar(32'd0, 1'b1);
      send_bar(32'd77, 1'b0);
      send_bar(32'd77, 1'b1);
      send_bar(32'd77, 1'b0);
      send_bar(32'd77, 1'b0);
   endtask

   task automatic test_window(int w, int factor, int bars);
      logic [31:0] p;
      write_register(CSR_WINDOW_LENGTH, w);
      write_register(CSR_ANNUAL_FACTOR, factor);
      p = $urandom();
      for (int i = 0; i < bars; i++) begin
         case ($urandom_range(0, 40))
            0: p = 0;
            1: p = $urandom();
            default: p = next_price(p);
         endcase
         send_bar(p, ($urandom_range(0, 150) == 0));
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.price = '0;
      req.restart = 1'b0;
      win_len = WINDOW_RESET;
      ann_factor = FACTOR_RESET;
      ring_ptr = 0;
      ret_sum = 0;
      sq_sum = 0;
      bar_count = 0;
      prev_price = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      write_register(CSR_ANNUAL_FACTOR, 16'd65535);
      test_extremes();
      test_window(0, 0, 20);
      test_window(1, 1, 30);
      test_window(2, 65535, 60);
      test_window(256, 252, 300);
      test_window(511, 252, 300);
      test_window(257, 12, 40);
      test_window(20, 252, 200);
      for (int k = 0; k < 8; k++) begin
         test_window($urandom_range(1, 64), $urandom_range(1, 65535), 50);
      end
      drain_results();

      $display("Covered %0d bars, %0d results, window lengths 0..511 and factors 0..65535.",
               bar_total, result_count);
      if (error_count == 0) begin
         $display("rolling_log_return_volatility_tb OK");
      end else begin
         $display("rolling_log_return_volatility_tb NOT OK");
      end
      $finish;
   end

endmodule
